// File: hw/rtl/irpw_pkg.sv
// ----------------------------------------------------------------------------
// irpw_pkg
// Shared types and constants for the infrared pulse-width transmitter.
// ----------------------------------------------------------------------------
package irpw_pkg;

    localparam int REG_W = 10;
    localparam int CMD_W = 8;
    localparam int IDX_W = 2;

    localparam logic [REG_W-1:0] START_MARK_RST  = 10'd228;
    localparam logic [REG_W-1:0] START_SPACE_RST = 10'd152;
    localparam logic [REG_W-1:0] LONG_RST        = 10'd92;
    localparam logic [REG_W-1:0] SHORT_RST       = 10'd46;

    typedef enum logic [IDX_W-1:0] {
        REG_START_MARK  = 2'd0,
        REG_START_SPACE = 2'd1,
        REG_LONG        = 2'd2,
        REG_SHORT       = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_START_MARK  = 3'd1,
        PH_START_SPACE = 3'd2,
        PH_BIT_MARK    = 3'd3,
        PH_BIT_SPACE   = 3'd4
    } phase_t;

endpackage

// File: hw/rtl/ir_pulse_width_transmitter.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_transmitter
// Sends a start burst, a start space and a command byte LSB first as
// pulse-width coded marks and spaces, one carrier half-period per tick beat.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  in        in_valid, in_stall, mode, command         into block
//  out       out_valid, out_stall, ir_level,
//            busy_res, frame_done                      out of block
//  cfg       cfg_we, cfg_index, cfg_data               into block
//
//  one beat per cycle unless in_stall holds it; the result is registered and appears in the cycle after the input beat
//  frame state and result register update in the same edge
//  a new beat is taken whenever the result register is empty or drained
//  reset clears the frame state and loads the default segment lengths
// ----------------------------------------------------------------------------
module ir_pulse_width_transmitter #(
    parameter int BITS_PER_FRAME = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic [irpw_pkg::CMD_W-1:0]   command,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         ir_level,
    output logic                         busy_res,
    output logic                         frame_done,
    input  logic                         cfg_we,
    input  logic [irpw_pkg::IDX_W-1:0]   cfg_index,
    input  logic [irpw_pkg::REG_W-1:0]   cfg_data
);

    localparam int BIT_W = $clog2(BITS_PER_FRAME + 1);

    logic [irpw_pkg::REG_W-1:0] start_mark_reg;
    logic [irpw_pkg::REG_W-1:0] start_space_reg;
    logic [irpw_pkg::REG_W-1:0] long_reg;
    logic [irpw_pkg::REG_W-1:0] short_reg;

    irpw_pkg::phase_t            phase_reg, phase_next;
    logic [irpw_pkg::REG_W-1:0]  tick_count_reg, tick_count_next;
    logic [BIT_W-1:0]            bit_index_reg, bit_index_next;
    logic [irpw_pkg::CMD_W-1:0]  shift_byte_reg, shift_byte_next;
    logic                        carrier_reg, carrier_next;

    logic                        out_valid_reg;
    logic                        ir_level_reg, ir_level_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    logic                        accept;
    logic [irpw_pkg::REG_W-1:0]  tick_inc;
    logic [irpw_pkg::REG_W-1:0]  seg_len;
    logic                        seg_end;
    logic [BIT_W-1:0]            bit_inc;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_mark_reg  <= irpw_pkg::START_MARK_RST;
            start_space_reg <= irpw_pkg::START_SPACE_RST;
            long_reg        <= irpw_pkg::LONG_RST;
            short_reg       <= irpw_pkg::SHORT_RST;
        end
        else if (cfg_we)
        begin
            unique case (irpw_pkg::reg_idx_t'(cfg_index))
                irpw_pkg::REG_START_MARK:  start_mark_reg  <= cfg_data;
                irpw_pkg::REG_START_SPACE: start_space_reg <= cfg_data;
                irpw_pkg::REG_LONG:        long_reg        <= cfg_data;
                irpw_pkg::REG_SHORT:       short_reg       <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // segment length for the current phase
    always_comb
    begin
        unique case (phase_reg)
            irpw_pkg::PH_START_MARK:  seg_len = start_mark_reg;
            irpw_pkg::PH_START_SPACE: seg_len = start_space_reg;
            irpw_pkg::PH_BIT_MARK:    seg_len = shift_byte_reg[0] ? long_reg : short_reg;
            irpw_pkg::PH_BIT_SPACE:   seg_len = shift_byte_reg[0] ? short_reg : long_reg;
            default:                  seg_len = '0;
        endcase
    end

    assign tick_inc = tick_count_reg + 1'b1;
    assign seg_end  = (tick_inc >= seg_len) || (tick_inc == '0);
    assign bit_inc  = bit_index_reg + 1'b1;

    // frame sequencer
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        carrier_next    = carrier_reg;
        done_next       = 1'b0;

        if (mode)
        begin
            if (phase_reg == irpw_pkg::PH_IDLE)
            begin
                shift_byte_next = command;
                bit_index_next  = '0;
                tick_count_next = '0;
                carrier_next    = 1'b0;
                phase_next      = irpw_pkg::PH_START_MARK;
            end
        end
        else
        begin
            unique case (phase_reg)
                irpw_pkg::PH_START_MARK,
                irpw_pkg::PH_BIT_MARK:
                begin
                    carrier_next    = !carrier_reg;
                    tick_count_next = tick_inc;
                    if (seg_end)
                    begin
                        tick_count_next = '0;
                        carrier_next    = 1'b0;
                        phase_next      = (phase_reg == irpw_pkg::PH_START_MARK) ?
                                          irpw_pkg::PH_START_SPACE :
                                          irpw_pkg::PH_BIT_SPACE;
                    end
                end
                irpw_pkg::PH_START_SPACE:
                begin
                    tick_count_next = tick_inc;
                    if (seg_end)
                    begin
                        tick_count_next = '0;
                        carrier_next    = 1'b0;
                        phase_next      = irpw_pkg::PH_BIT_MARK;
                    end
                end
                irpw_pkg::PH_BIT_SPACE:
                begin
                    tick_count_next = tick_inc;
                    if (seg_end)
                    begin
                        tick_count_next = '0;
                        shift_byte_next = shift_byte_reg >> 1;
                        if (bit_inc == BIT_W'(BITS_PER_FRAME))
                        begin
                            bit_index_next = '0;
                            phase_next     = irpw_pkg::PH_IDLE;
                            done_next      = 1'b1;
                        end
                        else
                        begin
                            bit_index_next = bit_inc;
                            phase_next     = irpw_pkg::PH_BIT_MARK;
                        end
                    end
                end
                default:
                begin
                    phase_next   = irpw_pkg::PH_IDLE;
                    carrier_next = 1'b0;
                end
            endcase
        end

        ir_level_next = ((phase_next == irpw_pkg::PH_START_MARK) ||
                         (phase_next == irpw_pkg::PH_BIT_MARK)) && carrier_next;
        busy_next     = (phase_next != irpw_pkg::PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= irpw_pkg::PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            shift_byte_reg <= '0;
            carrier_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
            carrier_reg    <= carrier_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ir_level_reg <= ir_level_next;
            busy_reg     <= busy_next;
            done_reg     <= done_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ir_level   = ir_level_reg;
    assign busy_res   = busy_reg;
    assign frame_done = done_reg;

    // checks
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> !busy_res)
        else $error("frame_done while still busy");

    a_level_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ir_level) |-> busy_res)
        else $error("emitter driven while idle");

    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == irpw_pkg::PH_IDLE) |-> (tick_count_reg == '0 && !carrier_reg))
        else $error("idle with live tick count or carrier");

    a_space_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == irpw_pkg::PH_START_SPACE) || (phase_reg == irpw_pkg::PH_BIT_SPACE))
        |-> !carrier_reg)
        else $error("carrier high during a space");

endmodule

// File: sim/ir_pulse_width_transmitter_tb.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_transmitter_tb
// Drives tick and start beats into the infrared pulse-width transmitter under
// several segment-length settings, predicts emitter level, busy and
// frame-done for every beat, and compares each result beat in order.
// ----------------------------------------------------------------------------
module ir_pulse_width_transmitter_tb;

    localparam int REG_W = irpw_pkg::REG_W;
    localparam int CMD_W = irpw_pkg::CMD_W;
    localparam int IDX_W = irpw_pkg::IDX_W;

    localparam int FRAME_BITS   = 8;
    localparam int RANDOM_BEATS = 350;

    typedef struct packed {
        logic ir;
        logic busy;
        logic done;
    } ir_beat_t;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             in_valid   = 1'b0;
    logic             in_stall;
    logic             mode       = 1'b0;
    logic [CMD_W-1:0] command    = '0;
    logic             out_valid;
    logic             out_stall  = 1'b0;
    logic             ir_level;
    logic             busy_res;
    logic             frame_done;
    logic             cfg_we     = 1'b0;
    logic [IDX_W-1:0] cfg_index  = '0;
    logic [REG_W-1:0] cfg_data   = '0;

    // transmitter shadow state
    logic [REG_W-1:0]  seg_len [4];
    irpw_pkg::phase_t  tx_phase;
    logic [REG_W-1:0]  tx_ticks;
    int                tx_bits_sent;
    logic [CMD_W-1:0]  tx_shift;
    logic              tx_carrier;

    ir_beat_t         pending_levels [$];
    int               error_count = 0;
    int               beat_count  = 0;
    bit               quiet       = 1'b0;
    int               stall_left  = 0;

    ir_pulse_width_transmitter #(
        .BITS_PER_FRAME(FRAME_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ir_level  (ir_level),
        .busy_res  (busy_res),
        .frame_done(frame_done),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("ir_pulse_width_transmitter_tb: done, errors");
        $finish;
    end

    function automatic bit segment_over(input logic [REG_W-1:0] len);
        tx_ticks = tx_ticks + 1'b1;
        if (tx_ticks >= len || tx_ticks == '0)
        begin
            tx_ticks = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [REG_W-1:0] bit_segment_len(input bit is_mark);
        return (tx_shift[0] == is_mark) ? seg_len[irpw_pkg::REG_LONG] :
                                          seg_len[irpw_pkg::REG_SHORT];
    endfunction

    task automatic step_transmitter(input logic m, input logic [CMD_W-1:0] cmd);
        ir_beat_t r;
        logic     done;
        done = 1'b0;
        if (m)
        begin
            if (tx_phase == irpw_pkg::PH_IDLE)
            begin
                tx_shift     = cmd;
                tx_bits_sent = 0;
                tx_ticks     = '0;
                tx_carrier   = 1'b0;
                tx_phase     = irpw_pkg::PH_START_MARK;
            end
        end
        else
        begin
            case (tx_phase)
                irpw_pkg::PH_START_MARK:
                begin
                    tx_carrier = ~tx_carrier;
                    if (segment_over(seg_len[irpw_pkg::REG_START_MARK]))
                    begin
                        tx_carrier = 1'b0;
                        tx_phase   = irpw_pkg::PH_START_SPACE;
                    end
                end
                irpw_pkg::PH_START_SPACE:
                begin
                    if (segment_over(seg_len[irpw_pkg::REG_START_SPACE]))
                    begin
                        tx_carrier = 1'b0;
                        tx_phase   = irpw_pkg::PH_BIT_MARK;
                    end
                end
                irpw_pkg::PH_BIT_MARK:
                begin
                    tx_carrier = ~tx_carrier;
                    if (segment_over(bit_segment_len(1'b1)))
                    begin
                        tx_carrier = 1'b0;
                        tx_phase   = irpw_pkg::PH_BIT_SPACE;
                    end
                end
                irpw_pkg::PH_BIT_SPACE:
                begin
                    if (segment_over(bit_segment_len(1'b0)))
                    begin
                        tx_shift     = tx_shift >> 1;
                        tx_bits_sent = tx_bits_sent + 1;
                        if (tx_bits_sent >= FRAME_BITS)
                        begin
                            tx_bits_sent = 0;
                            tx_phase     = irpw_pkg::PH_IDLE;
                            done         = 1'b1;
                        end
                        else
                        begin
                            tx_phase = irpw_pkg::PH_BIT_MARK;
                        end
                    end
                end
                default:
                begin
                    tx_phase   = irpw_pkg::PH_IDLE;
                    tx_carrier = 1'b0;
                end
            endcase
        end
        r.ir   = (tx_phase == irpw_pkg::PH_START_MARK || tx_phase == irpw_pkg::PH_BIT_MARK) ?
                 tx_carrier : 1'b0;
        r.busy = (tx_phase != irpw_pkg::PH_IDLE);
        r.done = done;
        pending_levels.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        error_count++;
    endtask

    // result side stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_levels.size() == 0)
            begin
                report_mismatch("result beat with nothing pending", 1, 0);
            end
            else
            begin
                if (ir_level !== pending_levels[0].ir)
                    report_mismatch("ir_level", ir_level, pending_levels[0].ir);
                if (busy_res !== pending_levels[0].busy)
                    report_mismatch("busy_res", busy_res, pending_levels[0].busy);
                if (frame_done !== pending_levels[0].done)
                    report_mismatch("frame_done", frame_done, pending_levels[0].done);
                void'(pending_levels.pop_front());
            end
        end
    end

    task automatic send_beat(input logic m, input logic [CMD_W-1:0] cmd);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        command  <= cmd;
        do
            @(posedge clk);
        while (in_stall);
        step_transmitter(m, cmd);
        beat_count++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_lengths(input logic [REG_W-1:0] mk, input logic [REG_W-1:0] sp,
                               input logic [REG_W-1:0] lg, input logic [REG_W-1:0] sh);
        logic [REG_W-1:0] vals [4];
        vals = '{mk, sp, lg, sh};
        drain_results();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= irpw_pkg::reg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            seg_len[i] = vals[i];
        end
        cfg_we <= 1'b0;
    endtask

    task automatic finish_frame();
        while (tx_phase != irpw_pkg::PH_IDLE)
            send_beat(1'b0, CMD_W'($urandom));
    endtask

    function automatic logic [REG_W-1:0] pick_len();
        return ($urandom_range(0, 7) == 0) ? '0 : REG_W'($urandom_range(1, 5));
    endfunction

    // reset lengths: start burst of 228 half-periods
    task automatic test_reset_lengths();
        send_beat(1'b0, 8'h00);
        send_beat(1'b1, 8'h5A);
        repeat (232) send_beat(1'b0, CMD_W'($urandom));
        drain_results();
    endtask

    // shortest segments, zero length, start while busy, all-ones and all-zeros bytes
    task automatic test_short_corners();
        set_lengths(10'd1, 10'd0, 10'd2, 10'd1);
        finish_frame();
        send_beat(1'b0, 8'hFF);
        send_beat(1'b1, 8'hFF);
        send_beat(1'b1, 8'h00);
        finish_frame();
        send_beat(1'b1, 8'h00);
        finish_frame();
        drain_results();
    endtask

    // longest segments, start burst keeps running
    task automatic test_max_lengths();
        set_lengths(10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_beat(1'b1, 8'hC3);
        repeat (60) send_beat(1'b0, CMD_W'($urandom));
        drain_results();
    endtask

    task automatic test_random_frames();
        int first_beat;
        int frames;
        first_beat = beat_count;
        while (beat_count - first_beat < RANDOM_BEATS)
        begin
            quiet = (beat_count - first_beat > RANDOM_BEATS * 4 / 5) ||
                    ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0)
                set_lengths(REG_W'($urandom_range(6, 16)), REG_W'($urandom_range(6, 16)),
                            REG_W'($urandom_range(6, 16)), REG_W'($urandom_range(6, 16)));
            else
                set_lengths(pick_len(), pick_len(), pick_len(), pick_len());
            frames = $urandom_range(1, 3);
            repeat (frames)
            begin
                repeat ($urandom_range(0, 2)) send_beat(1'b0, CMD_W'($urandom));
                send_beat(1'b1, CMD_W'($urandom));
                while (tx_phase != irpw_pkg::PH_IDLE)
                begin
                    if ($urandom_range(0, 24) == 0)
                        send_beat(1'b1, CMD_W'($urandom));
                    else
                        send_beat(1'b0, CMD_W'($urandom));
                end
                if ($urandom_range(0, 3) == 0)
                    drain_results();
            end
        end
    endtask

    initial
    begin
        seg_len[irpw_pkg::REG_START_MARK]  = irpw_pkg::START_MARK_RST;
        seg_len[irpw_pkg::REG_START_SPACE] = irpw_pkg::START_SPACE_RST;
        seg_len[irpw_pkg::REG_LONG]        = irpw_pkg::LONG_RST;
        seg_len[irpw_pkg::REG_SHORT]       = irpw_pkg::SHORT_RST;
        tx_phase     = irpw_pkg::PH_IDLE;
        tx_ticks     = '0;
        tx_bits_sent = 0;
        tx_shift     = '0;
        tx_carrier   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_lengths();
        test_short_corners();
        test_max_lengths();
        test_random_frames();

        quiet = 1'b1;
        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("ir_pulse_width_transmitter_tb: done, clean");
        else
            $display("ir_pulse_width_transmitter_tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/irpw_pkg.sv
hw/rtl/ir_pulse_width_transmitter.sv
sim/ir_pulse_width_transmitter_tb.sv
